// ----- hw/rtl/kmeans_point_cluster_defines.svh -----
`ifndef KMEANS_POINT_CLUSTER_DEFINES_SVH
`define KMEANS_POINT_CLUSTER_DEFINES_SVH

// Assertions clocked on clk and held off while rst_n is low.
`define KPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define KPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/kpc_pkg.sv -----
package kpc_pkg;

  localparam int KPC_MAX_POINTS   = 4096;
  localparam int KPC_MAX_CLUSTERS = 16;
  localparam int KPC_COORD_WIDTH  = 32;

  localparam int FUNC_W   = 3;
  localparam int IDX_W    = 12;
  localparam int STATUS_W = 2;
  localparam int ASN_W    = 4;
  localparam int OCRD_W   = 32;
  localparam int NCLU_W   = 5;
  localparam int MAXIT_W  = 10;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic REG_NUM_CLUSTERS = 1'b0;
  localparam logic REG_MAX_ITER     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODATA = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR    = 3'd0,
    FN_LOAD_PT  = 3'd1,
    FN_LOAD_CTR = 3'd2,
    FN_RUN      = 3'd3,
    FN_READ_ASN = 3'd4,
    FN_READ_CTR = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_RDA, S_RCLR, S_ASN, S_ACLR, S_ACC, S_DGO, S_DWAIT
  } state_t;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

  typedef struct packed {
    logic valid;
    logic acc;
  } tok_ctl_t;

  typedef struct packed {
    logic clr;
    logic div_go;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/kpc_cell.sv -----
module kpc_cell #(
  parameter int ID = 0,
  parameter int CW = 32,
  parameter int SW = 44,
  parameter int NW = 13,
  parameter int PW = 12,
  parameter int AW = 4,
  parameter int KW = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kpc_pkg::tok_ctl_t     ctl_i,
  input  logic [PW-1:0]         pidx_i,
  input  logic signed [CW-1:0]  x_i,
  input  logic signed [CW-1:0]  y_i,
  input  logic signed [CW-1:0]  z_i,
  input  logic [AW-1:0]         best_i,
  input  logic [AW-1:0]         old_i,
  input  logic [2*CW+3:0]       dist_i,
  output kpc_pkg::tok_ctl_t     ctl_o,
  output logic [PW-1:0]         pidx_o,
  output logic signed [CW-1:0]  x_o,
  output logic signed [CW-1:0]  y_o,
  output logic signed [CW-1:0]  z_o,
  output logic [AW-1:0]         best_o,
  output logic [AW-1:0]         old_o,
  output logic [2*CW+3:0]       dist_o,
  input  logic [KW-1:0]         k_i,
  input  kpc_pkg::cell_cmd_t    cmd_i,
  input  logic                  ld_we_i,
  input  logic signed [CW-1:0]  ld_x_i,
  input  logic signed [CW-1:0]  ld_y_i,
  input  logic signed [CW-1:0]  ld_z_i,
  output logic signed [CW-1:0]  cx_o,
  output logic signed [CW-1:0]  cy_o,
  output logic signed [CW-1:0]  cz_o,
  output logic                  busy_o
);
  import kpc_pkg::*;

  localparam int DW  = 2*CW+4;
  localparam int QW  = 2*CW+2;
  localparam int STW = (SW > 1) ? $clog2(SW) : 1;

  function automatic logic [CW:0] absdiff(input logic signed [CW-1:0] a,
                                          input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
  endfunction

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] s);
    return s[SW-1] ? SW'(-s) : SW'(s);
  endfunction

  logic en;
  assign en = (32'(ID) < 32'(k_i));

  logic signed [CW-1:0] cx_r, cy_r, cz_r;

  tok_ctl_t c1_r, c2_r, c3_r;
  logic [PW-1:0] pidx1_r, pidx2_r, pidx3_r;
  logic signed [CW-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r, x3_r, y3_r, z3_r;
  logic [AW-1:0] best1_r, best2_r, best3_r, old1_r, old2_r, old3_r;
  logic [DW-1:0] dist1_r, dist2_r, dist3_r;
  logic [CW:0] dx1_r, dy1_r, dz1_r;
  logic [QW-1:0] sqx2_r, sqy2_r, sqz2_r;
  logic [DW-1:0] sum2;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else begin
      c1_r <= ctl_i;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  assign sum2 = DW'(sqx2_r) + DW'(sqy2_r) + DW'(sqz2_r);
  assign take = c2_r.valid && !c2_r.acc && en && ((ID == 0) || (sum2 < dist2_r));

  always_ff @(posedge clk) begin
    pidx1_r <= pidx_i;
    x1_r    <= x_i;
    y1_r    <= y_i;
    z1_r    <= z_i;
    best1_r <= best_i;
    old1_r  <= old_i;
    dist1_r <= dist_i;
    dx1_r   <= absdiff(x_i, cx_r);
    dy1_r   <= absdiff(y_i, cy_r);
    dz1_r   <= absdiff(z_i, cz_r);
    pidx2_r <= pidx1_r;
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    z2_r    <= z1_r;
    best2_r <= best1_r;
    old2_r  <= old1_r;
    dist2_r <= dist1_r;
    sqx2_r  <= dx1_r * dx1_r;
    sqy2_r  <= dy1_r * dy1_r;
    sqz2_r  <= dz1_r * dz1_r;
    pidx3_r <= pidx2_r;
    x3_r    <= x2_r;
    y3_r    <= y2_r;
    z3_r    <= z2_r;
    old3_r  <= old2_r;
    best3_r <= take ? AW'(ID) : best2_r;
    dist3_r <= take ? sum2 : dist2_r;
  end

  assign ctl_o  = c3_r;
  assign pidx_o = pidx3_r;
  assign x_o    = x3_r;
  assign y_o    = y3_r;
  assign z_o    = z3_r;
  assign best_o = best3_r;
  assign old_o  = old3_r;
  assign dist_o = dist3_r;

  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic [NW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (cmd_i.clr) begin
      sx_r  <= '0;
      sy_r  <= '0;
      sz_r  <= '0;
      cnt_r <= '0;
    end else if (ctl_i.valid && ctl_i.acc && en && (best_i == AW'(ID))) begin
      sx_r  <= sx_r + SW'(x_i);
      sy_r  <= sy_r + SW'(y_i);
      sz_r  <= sz_r + SW'(z_i);
      cnt_r <= cnt_r + NW'(1);
    end
  end

  logic dv_busy_r, neg_r;
  axis_t axis_r;
  logic [STW-1:0] step_r;
  logic [NW-1:0] rem_r;
  logic [SW-1:0] dvd_r, quo_r, q_new, qs;
  logic [NW:0] rem_sh, rem_new;
  logic ge, last;

  assign rem_sh  = {rem_r, dvd_r[SW-1]};
  assign ge      = rem_sh >= (NW+1)'(cnt_r);
  assign rem_new = ge ? rem_sh - (NW+1)'(cnt_r) : rem_sh;
  assign q_new   = {quo_r[SW-2:0], ge};
  assign qs      = neg_r ? SW'(-q_new) : q_new;
  assign last    = (step_r == STW'(SW-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (!dv_busy_r) begin
      if (cmd_i.div_go && en && (cnt_r != '0)) begin
        dv_busy_r <= 1'b1;
        axis_r    <= AX_X;
        step_r    <= '0;
        rem_r     <= '0;
        quo_r     <= '0;
        dvd_r     <= mag(sx_r);
        neg_r     <= sx_r[SW-1];
      end
    end else begin
      rem_r  <= rem_new[NW-1:0];
      quo_r  <= q_new;
      dvd_r  <= dvd_r << 1;
      step_r <= step_r + STW'(1);
      if (last) begin
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        case (axis_r)
          AX_X: begin
            axis_r <= AX_Y;
            dvd_r  <= mag(sy_r);
            neg_r  <= sy_r[SW-1];
          end
          AX_Y: begin
            axis_r <= AX_Z;
            dvd_r  <= mag(sz_r);
            neg_r  <= sz_r[SW-1];
          end
          default: dv_busy_r <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we_i) begin
      cx_r <= ld_x_i;
      cy_r <= ld_y_i;
      cz_r <= ld_z_i;
    end else if (dv_busy_r && last) begin
      case (axis_r)
        AX_X:    cx_r <= qs[CW-1:0];
        AX_Y:    cy_r <= qs[CW-1:0];
        default: cz_r <= qs[CW-1:0];
      endcase
    end
  end

  assign cx_o   = cx_r;
  assign cy_o   = cy_r;
  assign cz_o   = cz_r;
  assign busy_o = dv_busy_r;

endmodule

// ----- hw/rtl/kmeans_point_cluster.sv -----
// Lloyd k-means over loaded 3D points in signed Q16.16. Clear, load point, load center and
// read center register their result in the cycle after the word is taken and may follow
// one another every cycle while each result is taken; read assignment passes through the
// registered read port of the assignment memory and a read state before its result is
// registered. Every pass streams all points through the chain of center cells twice, once
// to find the nearest center and once to accumulate sums; then each enabled cell with
// members divides its three sums by its member count bit-serially in 3*SW divide steps (132
// at the defaults, SW = COORD_WIDTH + log2(MAX_POINTS)). After reset the block clears the
// assignment memory and accepts no word until that is done; register writes are taken then.
`include "kmeans_point_cluster_defines.svh"

module kmeans_point_cluster #(
  parameter int MAX_POINTS   = kpc_pkg::KPC_MAX_POINTS,
  parameter int MAX_CLUSTERS = kpc_pkg::KPC_MAX_CLUSTERS,
  parameter int COORD_WIDTH  = kpc_pkg::KPC_COORD_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kpc_pkg::FUNC_W-1:0]           in_func,
  input  logic signed [kpc_pkg::OCRD_W-1:0]    in_coord_x,
  input  logic signed [kpc_pkg::OCRD_W-1:0]    in_coord_y,
  input  logic signed [kpc_pkg::OCRD_W-1:0]    in_coord_z,
  input  logic [kpc_pkg::IDX_W-1:0]            in_item_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [kpc_pkg::STATUS_W-1:0]         out_status,
  output logic [kpc_pkg::ASN_W-1:0]            out_assigned_cluster,
  output logic signed [kpc_pkg::OCRD_W-1:0]    out_x,
  output logic signed [kpc_pkg::OCRD_W-1:0]    out_y,
  output logic signed [kpc_pkg::OCRD_W-1:0]    out_z,
  output logic [kpc_pkg::MAXIT_W-1:0]          out_passes_done,
  output logic                                 out_converged,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kpc_pkg::PADDR_W-1:0]          paddr,
  input  logic [kpc_pkg::PDATA_W-1:0]          pwdata,
  output logic [kpc_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);
  import kpc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW = $clog2(MAX_CLUSTERS + 1);
  localparam int SW = CW + $clog2(MAX_POINTS);
  localparam int DW = 2*CW + 4;

  state_t state_r, state_nxt;
  logic [NCLU_W-1:0] nclu_r;
  logic [MAXIT_W-1:0] maxit_r, passes_r;
  logic [NW-1:0] pts_r, cnt_r, ex_r;
  logic [KW-1:0] ctrs_r, k_r;
  logic chg_r;
  tok_ctl_t tok_r;
  logic [PW-1:0] tokp_r;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nclu_r  <= NCLU_W'(1);
      maxit_r <= MAXIT_W'(100);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_NUM_CLUSTERS) nclu_r <= pwdata[NCLU_W-1:0];
      else maxit_r <= pwdata[MAXIT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_ITER) prdata = PDATA_W'(maxit_r);
    else prdata = PDATA_W'(nclu_r);
  end

  // Request decode.
  logic acc_in;
  func_t fn;
  logic [31:0] nc32, kc;
  logic pt_room, ctr_room, run_ok, asn_in, ctr_in;
  logic [AW-1:0] cidx;

  assign in_ready = (state_r == S_IDLE) && (!out_valid || out_ready);
  assign acc_in   = in_valid && in_ready;
  assign fn       = func_t'(in_func);
  assign nc32     = 32'(nclu_r);
  assign kc       = (nc32 == 32'd0) ? 32'd1 :
                    (nc32 > 32'(MAX_CLUSTERS)) ? 32'(MAX_CLUSTERS) : nc32;
  assign pt_room  = 32'(pts_r) < 32'(MAX_POINTS);
  assign ctr_room = 32'(ctrs_r) < 32'(MAX_CLUSTERS);
  assign run_ok   = (pts_r != '0) && (32'(ctrs_r) >= kc);
  assign asn_in   = 32'(in_item_index) < 32'(pts_r);
  assign ctr_in   = 32'(in_item_index) < 32'(ctrs_r);
  assign cidx     = AW'(in_item_index);

  // Chain of center cells.
  tok_ctl_t ch_ctl [MAX_CLUSTERS+1];
  logic [PW-1:0] ch_pidx [MAX_CLUSTERS+1];
  logic signed [CW-1:0] ch_x [MAX_CLUSTERS+1];
  logic signed [CW-1:0] ch_y [MAX_CLUSTERS+1];
  logic signed [CW-1:0] ch_z [MAX_CLUSTERS+1];
  logic [AW-1:0] ch_best [MAX_CLUSTERS+1];
  logic [AW-1:0] ch_old [MAX_CLUSTERS+1];
  logic [DW-1:0] ch_dist [MAX_CLUSTERS+1];
  logic signed [CW-1:0] cen_x [MAX_CLUSTERS];
  logic signed [CW-1:0] cen_y [MAX_CLUSTERS];
  logic signed [CW-1:0] cen_z [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] busy;
  cell_cmd_t cmd;

  logic signed [CW-1:0] ptx_q, pty_q, ptz_q;
  logic [AW-1:0] asn_q;

  assign cmd.clr    = (state_r == S_ACLR);
  assign cmd.div_go = (state_r == S_DGO);

  assign ch_ctl[0]  = tok_r;
  assign ch_pidx[0] = tokp_r;
  assign ch_x[0]    = ptx_q;
  assign ch_y[0]    = pty_q;
  assign ch_z[0]    = ptz_q;
  assign ch_best[0] = asn_q;
  assign ch_old[0]  = asn_q;
  assign ch_dist[0] = '0;

  for (genvar j = 0; j < MAX_CLUSTERS; j++) begin : g_cell
    kpc_cell #(
      .ID(j), .CW(CW), .SW(SW), .NW(NW), .PW(PW), .AW(AW), .KW(KW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ch_ctl[j]),
      .pidx_i  (ch_pidx[j]),
      .x_i     (ch_x[j]),
      .y_i     (ch_y[j]),
      .z_i     (ch_z[j]),
      .best_i  (ch_best[j]),
      .old_i   (ch_old[j]),
      .dist_i  (ch_dist[j]),
      .ctl_o   (ch_ctl[j+1]),
      .pidx_o  (ch_pidx[j+1]),
      .x_o     (ch_x[j+1]),
      .y_o     (ch_y[j+1]),
      .z_o     (ch_z[j+1]),
      .best_o  (ch_best[j+1]),
      .old_o   (ch_old[j+1]),
      .dist_o  (ch_dist[j+1]),
      .k_i     (k_r),
      .cmd_i   (cmd),
      .ld_we_i (acc_in && (fn == FN_LOAD_CTR) && ctr_room && (32'(ctrs_r) == 32'(j))),
      .ld_x_i  (in_coord_x[CW-1:0]),
      .ld_y_i  (in_coord_y[CW-1:0]),
      .ld_z_i  (in_coord_z[CW-1:0]),
      .cx_o    (cen_x[j]),
      .cy_o    (cen_y[j]),
      .cz_o    (cen_z[j]),
      .busy_o  (busy[j])
    );
  end

  logic ex_v, ex_last, sweep_last, wipe_last, any_busy, pass_end, iss;

  assign ex_v       = ch_ctl[MAX_CLUSTERS].valid;
  assign ex_last    = (32'(ex_r) + 32'd1) == 32'(pts_r);
  assign sweep_last = (32'(cnt_r) + 32'd1) == 32'(pts_r);
  assign wipe_last  = (32'(cnt_r) + 32'd1) == 32'(MAX_POINTS);
  assign any_busy   = |busy;
  assign pass_end   = !chg_r || ((passes_r + MAXIT_W'(1)) == maxit_r);
  assign iss        = ((state_r == S_ASN) || (state_r == S_ACC)) && (cnt_r < pts_r);

  // Point and assignment memories.
  logic signed [CW-1:0] ptx_mem [MAX_POINTS];
  logic signed [CW-1:0] pty_mem [MAX_POINTS];
  logic signed [CW-1:0] ptz_mem [MAX_POINTS];
  logic [AW-1:0] asn_mem [MAX_POINTS];
  logic [PW-1:0] rd_addr, pt_waddr, asn_waddr;
  logic pt_we, asn_we;
  logic [AW-1:0] asn_wdata;

  assign rd_addr   = (state_r == S_IDLE) ? PW'(in_item_index) : cnt_r[PW-1:0];
  assign pt_we     = acc_in && (fn == FN_LOAD_PT) && pt_room;
  assign pt_waddr  = pts_r[PW-1:0];
  assign asn_we    = (state_r == S_WIPE) || (state_r == S_RCLR) ||
                     ((state_r == S_ASN) && ex_v);
  assign asn_waddr = (state_r == S_ASN) ? ch_pidx[MAX_CLUSTERS] : cnt_r[PW-1:0];
  assign asn_wdata = (state_r == S_ASN) ? ch_best[MAX_CLUSTERS] : '0;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      ptx_mem[pt_waddr] <= in_coord_x[CW-1:0];
      pty_mem[pt_waddr] <= in_coord_y[CW-1:0];
      ptz_mem[pt_waddr] <= in_coord_z[CW-1:0];
    end
    ptx_q <= ptx_mem[rd_addr];
    pty_q <= pty_mem[rd_addr];
    ptz_q <= ptz_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (asn_we) asn_mem[asn_waddr] <= asn_wdata;
    asn_q <= asn_mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_WIPE:  if (wipe_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (acc_in && (fn == FN_READ_ASN) && asn_in) state_nxt = S_RDA;
        else if (acc_in && (fn == FN_RUN) && run_ok) state_nxt = S_RCLR;
      end
      S_RDA:   state_nxt = S_IDLE;
      S_RCLR:  if (sweep_last) state_nxt = (maxit_r == '0) ? S_IDLE : S_ASN;
      S_ASN:   if (ex_v && ex_last) state_nxt = S_ACLR;
      S_ACLR:  state_nxt = S_ACC;
      S_ACC:   if (ex_v && ex_last) state_nxt = S_DGO;
      S_DGO:   state_nxt = S_DWAIT;
      S_DWAIT: if (!any_busy) state_nxt = pass_end ? S_IDLE : S_ASN;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic res_v, res_conv;
  logic [STATUS_W-1:0] res_status;
  logic [ASN_W-1:0] res_asn;
  logic signed [OCRD_W-1:0] res_x, res_y, res_z;
  logic [MAXIT_W-1:0] res_passes;

  always_comb begin
    res_v      = 1'b0;
    res_status = ST_OK;
    res_asn    = '0;
    res_x      = '0;
    res_y      = '0;
    res_z      = '0;
    res_passes = '0;
    res_conv   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          unique case (fn)
            FN_CLEAR: res_v = 1'b1;
            FN_LOAD_PT: begin
              res_v = 1'b1;
              if (!pt_room) res_status = ST_RANGE;
            end
            FN_LOAD_CTR: begin
              res_v = 1'b1;
              if (!ctr_room) res_status = ST_RANGE;
            end
            FN_RUN: begin
              if (!run_ok) begin
                res_v      = 1'b1;
                res_status = ST_NODATA;
              end
            end
            FN_READ_ASN: begin
              if (!asn_in) begin
                res_v      = 1'b1;
                res_status = ST_RANGE;
              end
            end
            FN_READ_CTR: begin
              res_v = 1'b1;
              if (ctr_in) begin
                res_x = OCRD_W'(cen_x[cidx]);
                res_y = OCRD_W'(cen_y[cidx]);
                res_z = OCRD_W'(cen_z[cidx]);
              end else begin
                res_status = ST_RANGE;
              end
            end
            default: res_v = 1'b0;
          endcase
        end
      end
      S_RDA: begin
        res_v   = 1'b1;
        res_asn = ASN_W'(asn_q);
      end
      S_RCLR:  res_v = sweep_last && (maxit_r == '0);
      S_DWAIT: begin
        if (!any_busy && pass_end) begin
          res_v      = 1'b1;
          res_passes = passes_r + MAXIT_W'(1);
          res_conv   = !chg_r;
        end
      end
      default: res_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_WIPE;
      cnt_r    <= '0;
      ex_r     <= '0;
      pts_r    <= '0;
      ctrs_r   <= '0;
      k_r      <= KW'(1);
      passes_r <= '0;
      chg_r    <= 1'b0;
      tok_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      tok_r.valid <= iss;
      tok_r.acc   <= (state_r == S_ACC);
      case (state_r)
        S_WIPE, S_RCLR: begin
          cnt_r <= (state_nxt != state_r) ? '0 : cnt_r + NW'(1);
          ex_r  <= '0;
          chg_r <= 1'b0;
        end
        S_IDLE: begin
          cnt_r    <= '0;
          ex_r     <= '0;
          passes_r <= '0;
          if (acc_in) begin
            case (fn)
              FN_CLEAR: begin
                pts_r  <= '0;
                ctrs_r <= '0;
              end
              FN_LOAD_PT:  if (pt_room) pts_r <= pts_r + NW'(1);
              FN_LOAD_CTR: if (ctr_room) ctrs_r <= ctrs_r + KW'(1);
              FN_RUN:      k_r <= KW'(kc);
              default:     k_r <= k_r;
            endcase
          end
        end
        S_ASN, S_ACC: begin
          if (iss) cnt_r <= cnt_r + NW'(1);
          if (ex_v) begin
            ex_r <= ex_r + NW'(1);
            if (state_r == S_ASN && ch_best[MAX_CLUSTERS] != ch_old[MAX_CLUSTERS]) begin
              chg_r <= 1'b1;
            end
          end
        end
        S_ACLR: begin
          cnt_r <= '0;
          ex_r  <= '0;
        end
        S_DWAIT: begin
          cnt_r <= '0;
          ex_r  <= '0;
          if (!any_busy) begin
            passes_r <= passes_r + MAXIT_W'(1);
            if (!pass_end) chg_r <= 1'b0;
          end
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tokp_r <= cnt_r[PW-1:0];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (res_v) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      out_status           <= res_status;
      out_assigned_cluster <= res_asn;
      out_x                <= res_x;
      out_y                <= res_y;
      out_z                <= res_z;
      out_passes_done      <= res_passes;
      out_converged        <= res_conv;
    end
  end

  `KPC_ASSERT_IMP(a_in_out_free, in_valid && in_ready, !out_valid || out_ready, "word taken while result blocked")
  `KPC_ASSERT_IMP(a_exit_in_walk, ch_ctl[MAX_CLUSTERS].valid, (state_r == S_ASN) || (state_r == S_ACC), "chain word outside a walk")
  `KPC_ASSERT_IMP(a_pass_bound, state_r == S_ASN, passes_r < maxit_r, "pass count beyond limit")
  `KPC_ASSERT_NXT(a_div_start, state_r == S_DGO, state_r == S_DWAIT, "divide start not followed by wait")

endmodule
